### design/kvt_pkg.sv
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef logic [KEY_WIDTH-1:0]   key_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_GET    = 2'd1,
    OP_SET    = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic apply;
  } kvt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } kvt_stat_t;

endpackage

### design/key_value_table.sv
`timescale 1ns / 1ps
// A request is handled in steps: the scan reads every entry in turn through the
// single key comparator, a settle state finishes the last compare, and an apply
// state writes back and loads the result register once the output is free.
// A new request is taken only after the previous one has been applied.
// Reset (rst, synchronous): all entries invalid, entry count zero, no result.
module key_value_table import kvt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] lookup_key,
  input  logic [31:0] new_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [31:0] read_value,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);

  kvt_cmd_t  cmd;
  kvt_stat_t stat;

  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  kvt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (opcode),
    .lookup_key  (lookup_key),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

### design/kvt_ctrl.sv
`timescale 1ns / 1ps

module kvt_ctrl import kvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  kvt_stat_t stat,
  output kvt_cmd_t  cmd,
  output logic      in_stall
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SETTLE,
    S_APPLY
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.scan_last) begin
            state <= S_SETTLE;
          end
        end
        S_SETTLE: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd.start = (state == S_IDLE) && in_valid;
    cmd.scan  = (state == S_SCAN);
    // The result register must be empty or emptying before a new result lands.
    cmd.apply = (state == S_APPLY) && stat.out_free;
  end

  assign in_stall = (state != S_IDLE);

endmodule

### design/kvt_datapath.sv
`timescale 1ns / 1ps

module kvt_datapath import kvt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  kvt_cmd_t    cmd,
  output kvt_stat_t   stat,
  input  logic [1:0]  opcode,
  input  logic [31:0] lookup_key,
  input  logic [31:0] new_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [31:0] read_value,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);

  key_t   key_mem [ENTRIES];
  value_t val_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_bits;
  cnt_t   count;

  opcode_t op;
  key_t    key;
  value_t  value;

  idx_t    idx;
  logic    rd_vld;
  logic    rd_entry_valid;
  key_t    rd_key;
  value_t  rd_value;
  idx_t    rd_idx;

  logic    match_found;
  idx_t    match_slot;
  value_t  match_value;
  logic    free_found;
  idx_t    free_slot;

  logic    wr_en;
  logic    wr_key_en;
  idx_t    wr_addr;
  logic    set_valid;
  logic    clr_valid;
  cnt_t    count_next;
  value_t  rv_next;
  status_t st_next;

  assign stat.scan_last = (idx == idx_t'(ENTRIES - 1));
  assign stat.out_free  = !out_valid || !out_stall;

  // Decision taken once the scan has settled.
  always_comb begin
    wr_en      = 1'b0;
    wr_key_en  = 1'b0;
    wr_addr    = match_slot;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    count_next = count;
    rv_next    = '0;
    st_next    = ST_OK;
    unique case (op)
      OP_FIND: begin
        st_next = ST_OK;
      end
      OP_GET: begin
        if (match_found) begin
          rv_next = match_value;
        end else begin
          st_next = ST_NOT_FOUND;
        end
      end
      OP_SET: begin
        if (match_found) begin
          wr_en = 1'b1;
        end else if (free_found) begin
          wr_en      = 1'b1;
          wr_key_en  = 1'b1;
          wr_addr    = free_slot;
          set_valid  = 1'b1;
          count_next = count + cnt_t'(1);
        end else begin
          st_next = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (match_found) begin
          rv_next    = match_value;
          clr_valid  = 1'b1;
          count_next = count - cnt_t'(1);
        end else begin
          st_next = ST_NOT_FOUND;
        end
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  // Entry storage, one read and one write per cycle.
  always_ff @(posedge clk) begin
    rd_key         <= key_mem[idx];
    rd_value       <= val_mem[idx];
    rd_entry_valid <= valid_bits[idx];
    rd_idx         <= idx;
    if (cmd.apply && wr_en) begin
      val_mem[wr_addr] <= value;
      if (wr_key_en) begin
        key_mem[wr_addr] <= key;
      end
    end
  end

  // Request capture and the compare stage of the scan.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op    <= opcode_t'(opcode);
      key   <= lookup_key[KEY_WIDTH-1:0];
      value <= new_value[VALUE_WIDTH-1:0];
    end
    if (rd_vld) begin
      if (rd_entry_valid && (rd_key == key) && !match_found) begin
        match_slot  <= rd_idx;
        match_value <= rd_value;
      end
      if (!rd_entry_valid && !free_found) begin
        free_slot <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      rd_vld      <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      valid_bits  <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
      if (cmd.start) begin
        idx         <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else begin
        if (cmd.scan) begin
          idx <= idx + idx_t'(1);
        end
        if (rd_vld && rd_entry_valid && (rd_key == key)) begin
          match_found <= 1'b1;
        end
        if (rd_vld && !rd_entry_valid) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.apply) begin
        if (set_valid) begin
          valid_bits[wr_addr] <= 1'b1;
        end
        if (clr_valid) begin
          valid_bits[match_slot] <= 1'b0;
        end
        count <= count_next;
      end
      if (cmd.apply) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; it is only reloaded when the previous transfer completes.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      hit        <= match_found;
      read_value <= 32'(rv_next);
      status     <= st_next;
    end
  end

  assign entry_count = 5'(count);

endmodule

### design/kvt_checker.sv
`timescale 1ns / 1ps

module kvt_checker import kvt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  opcode,
  input logic [31:0] lookup_key,
  input logic [31:0] new_value,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic [31:0] read_value,
  input logic [1:0]  status,
  input logic [4:0]  entry_count
);

  // A stalled request keeps its contents until it transfers.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(lookup_key)
      && $stable(new_value))
    else $error("request changed while stalled");

  // A held result keeps its read value and status.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status))
    else $error("result changed while stalled");

  // A full status only appears on a miss when every entry is in use.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> !hit && (entry_count == 5'(ENTRIES)))
    else $error("full status with free entries or a hit");

  // A miss reports no data.
  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOT_FOUND) |-> !hit && (read_value == 32'd0))
    else $error("not-found result carries a hit or data");

  // Every request that finds its key succeeds.
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> (status == ST_OK) && (entry_count <= 5'(ENTRIES)))
    else $error("hit with a failing status");

endmodule

bind key_value_table kvt_checker u_kvt_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import kvt_pkg::*;

  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 600;
  localparam int KEY_POOL = 24;

  typedef struct {
    logic    hit;
    value_t  read_value;
    status_t status;
    cnt_t    entry_count;
  } reply_t;

  typedef struct {
    opcode_t op;
    key_t    key;
    value_t  val;
    bit      typed;
    reply_t  want;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [31:0] lookup_key = '0;
  logic [31:0] new_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic [4:0]  entry_count;

  // Shadow copy of the table contents.
  bit     slot_used [ENTRIES];
  key_t   slot_key  [ENTRIES];
  value_t slot_val  [ENTRIES];
  cnt_t   used_count = '0;

  reply_t       pending_replies [$];
  request_row_t directed_rows [$];
  key_t         key_pool [KEY_POOL];
  int           mismatch_count = 0;
  bit           hold_outputs = 1'b0;
  bit           in_quiet = 1'b0;
  bit           out_quiet = 1'b0;

  key_value_table i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .lookup_key (lookup_key),
    .new_value  (new_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .read_value (read_value),
    .status     (status),
    .entry_count(entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic reply_t apply_request(opcode_t op, key_t key, value_t val);
    reply_t r;
    int     slot;
    int     free_idx;
    slot = -1;
    free_idx = -1;
    // Walk downward so that the lowest-numbered match and free slot win.
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == key) slot = i;
      if (!slot_used[i]) free_idx = i;
    end
    r.hit = (slot >= 0);
    r.read_value = '0;
    r.status = ST_OK;
    case (op)
      OP_FIND: begin
      end
      OP_GET: begin
        if (r.hit) r.read_value = slot_val[slot];
        else r.status = ST_NOT_FOUND;
      end
      OP_SET: begin
        if (r.hit) begin
          slot_val[slot] = val;
        end else if (free_idx >= 0) begin
          slot_used[free_idx] = 1'b1;
          slot_key[free_idx] = key;
          slot_val[free_idx] = val;
          used_count = used_count + 1'b1;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (r.hit) begin
          r.read_value = slot_val[slot];
          slot_used[slot] = 1'b0;
          used_count = used_count - 1'b1;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
    endcase
    r.entry_count = used_count;
    return r;
  endfunction

  function automatic void add_row(opcode_t op, key_t key, value_t val, bit typed,
                                  logic h, value_t rd, status_t st, cnt_t cnt);
    request_row_t row;
    row.op = op;
    row.key = key;
    row.val = val;
    row.typed = typed;
    row.want.hit = h;
    row.want.read_value = rd;
    row.want.status = st;
    row.want.entry_count = cnt;
    directed_rows.push_back(row);
  endfunction

  // Offers one request and returns at the edge where it transfers.
  task automatic offer_request(opcode_t op, key_t key, value_t val, bit typed,
                               reply_t want);
    int     gap;
    reply_t got;
    gap = in_quiet ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    lookup_key <= key;
    new_value <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = apply_request(op, key, val);
    pending_replies.push_back(typed ? want : got);
  endtask

  task automatic wait_for_drain();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold on request, and the field checks.
  initial begin
    reply_t want;
    int     gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_outputs) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_outputs = 1'b0;
      end
      gap = out_quiet ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit %0b value %h status %0d count %0d",
                 $time, hit, read_value, status, entry_count);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
          mismatch_count++;
        end
        if (read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   read_value);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          mismatch_count++;
        end
        if (entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                   entry_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    request_row_t row;
    reply_t       none;
    opcode_t      op;
    key_t         key;
    bit           fill_phase;
    int           pick;

    none.hit = 1'b0;
    none.read_value = '0;
    none.status = ST_OK;
    none.entry_count = '0;

    add_row(OP_FIND,   32'h0000_0000, 32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
    add_row(OP_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 32'h0, ST_NOT_FOUND, 0);
    add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1, 0, 32'h0, ST_NOT_FOUND, 0);
    add_row(OP_SET,    32'h0000_0000, 32'hFFFF_FFFF, 1, 0, 32'h0, ST_OK, 1);
    add_row(OP_SET,    32'hFFFF_FFFF, 32'h0000_0000, 1, 0, 32'h0, ST_OK, 2);
    add_row(OP_GET,    32'h0000_0000, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_OK, 2);
    add_row(OP_SET,    32'h0000_0000, 32'h5A5A_5A5A, 1, 1, 32'h0, ST_OK, 2);
    add_row(OP_FIND,   32'hFFFF_FFFF, 32'hA5A5_A5A5, 1, 1, 32'h0, ST_OK, 2);
    for (int i = 0; i < ENTRIES - 2; i++) begin
      add_row(OP_SET, 32'h0000_0100 + i, $urandom, 0, 0, 32'h0, ST_OK, 0);
    end
    // The table is full now: a new key is refused, a present key is still updated.
    add_row(OP_SET,    32'h8000_0001, 32'h1111_1111, 1, 0, 32'h0, ST_FULL, 16);
    add_row(OP_SET,    32'hFFFF_FFFF, 32'h1234_5678, 1, 1, 32'h0, ST_OK, 16);
    add_row(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 32'h1234_5678, ST_OK, 15);
    add_row(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1, 0, 32'h0, ST_NOT_FOUND, 15);
    add_row(OP_GET,    32'h0000_0000, 32'h0000_0000, 0, 0, 32'h0, ST_OK, 0);

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_request(row.op, row.key, row.val, row.typed, row.want);
    end

    // A pool larger than the table lets the set-heavy phases fill it up,
    // while the remove-heavy phases drain it again.
    fill_phase = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 59) fill_phase = !fill_phase;
      if (n == 150 || n == 420) hold_outputs = 1'b1;
      if (n == 300) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait_for_drain();
      end
      pick = $urandom_range(0, 99);
      if (fill_phase) begin
        op = (pick < 50) ? OP_SET : (pick < 70) ? OP_GET : (pick < 85) ? OP_FIND : OP_REMOVE;
      end else begin
        op = (pick < 20) ? OP_SET : (pick < 40) ? OP_GET : (pick < 55) ? OP_FIND : OP_REMOVE;
      end
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      offer_request(op, key, $urandom, 0, none);
    end

    in_valid <= 1'b0;
    wait_for_drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
